@@ hw/rtl/crrf_pkg.sv @@
// shared types and constants of the checksummed request/response framer
`default_nettype none
package crrf_pkg;

  localparam int unsigned MAX_FRAME = 1024;

  // input function codes
  localparam logic [1:0] FUNC_REQ  = 2'd0;
  localparam logic [1:0] FUNC_RX   = 2'd1;
  localparam logic [1:0] FUNC_TICK = 2'd2;

  // result kinds
  localparam logic [1:0] KIND_TX     = 2'd0;
  localparam logic [1:0] KIND_REPLY  = 2'd1;
  localparam logic [1:0] KIND_STATUS = 2'd2;

  // transaction status codes
  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_NO_RESP   = 3'd1;
  localparam logic [2:0] ST_SHORT     = 3'd2;
  localparam logic [2:0] ST_BAD_SUM   = 3'd3;
  localparam logic [2:0] ST_WRONG_CMD = 3'd4;
  localparam logic [2:0] ST_WRONG_DST = 3'd5;

  // register indexes
  localparam logic [1:0] REG_RESP_TO = 2'd0;
  localparam logic [1:0] REG_GAP_TO  = 2'd1;
  localparam logic [1:0] REG_CHK_CMD = 2'd2;
  localparam logic [1:0] REG_CHK_DST = 2'd3;

  localparam logic [9:0] RESP_TO_RESET = 10'd1000;
  localparam logic [7:0] GAP_TO_RESET  = 8'd20;

  localparam logic [10:0] TICK_MAX  = 11'h7ff;
  localparam logic [10:0] FRAME_MAX = 11'(MAX_FRAME);

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  out_byte;
    logic [9:0]  byte_position;
    logic [2:0]  status;
    logic [10:0] reply_length;
    logic        last;
  } res_t;

  // frame position saturates at 1023
  function automatic logic [9:0] clamp_pos(input logic [10:0] v);
    clamp_pos = v[10] ? 10'h3ff : v[9:0];
  endfunction

endpackage
`default_nettype wire

@@ hw/rtl/checksummed_request_response_framer.sv @@
// top level of the checksummed request/response framer
//
// in_*  : one transfer per item; func selects request byte, received line byte
//         or one-millisecond tick.
// out_* : result transfers; a request byte yields its echo for transmission,
//         the last request byte also yields the checksum byte; received bytes
//         come out one byte late; ticks may yield a transaction status.
// psel/penable/pwrite/paddr/pwdata/prdata/pready : register port, byte
//         addresses 0,4,8,12 for response timeout, gap timeout, command check
//         and destination check; pready is always high.
// queueing: the results of an item enter the output queue when the item is
//         accepted; the checksum byte is offered right after its echo is taken.
// throughput: one item per cycle while the receiver takes a result each cycle;
//         the last request byte puts two results into the four-entry output
//         queue, which drains one per cycle.
// in_ready is high while at least two queue slots are free, so a stalled
//         receiver backs up into the input once three results are waiting.
// reset: registers return to their reset values, the framer goes idle and
//         the output queue empties.
`default_nettype none
module checksummed_request_response_framer (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  in_func,
  input  wire logic [7:0]  in_data_byte,
  input  wire logic        in_request_last,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [1:0]       out_kind,
  output logic [7:0]       out_out_byte,
  output logic [9:0]       out_byte_position,
  output logic [2:0]       out_status,
  output logic [10:0]      out_reply_length,
  output logic             out_last,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);
  import crrf_pkg::*;

  typedef enum logic [1:0] {PH_IDLE, PH_SEND, PH_WAIT, PH_RECV} phase_t;

  phase_t      phase_r, phase_nxt;
  logic [9:0]  resp_to_r;
  logic [7:0]  gap_to_r;
  logic        chk_cmd_r, chk_dst_r;
  logic [7:0]  send_sum_r, send_sum_nxt;
  logic [10:0] send_cnt_r, send_cnt_nxt;
  logic [7:0]  sent_cmd_r, sent_cmd_nxt;
  logic [7:0]  sent_dst_r, sent_dst_nxt;
  logic [10:0] tick_r, tick_nxt;
  logic [7:0]  reply_sum_r, reply_sum_nxt;
  logic [7:0]  held_r, held_nxt;
  logic [10:0] reply_cnt_r, reply_cnt_nxt;
  logic [7:0]  reply_cmd_r, reply_cmd_nxt;
  logic [7:0]  reply_dst_r, reply_dst_nxt;

  res_t        q_mem [4];
  logic [1:0]  wr_ptr_r, rd_ptr_r;
  logic [2:0]  cnt_r;

  logic        in_xfer, out_xfer, cfg_wr;
  logic [1:0]  push_n;
  res_t        res0, res1;
  logic [7:0]  sum_base;
  logic [10:0] cnt_base;
  logic [10:0] cnt_inc;
  logic [10:0] tick_inc;
  logic [9:0]  rpos;
  logic [2:0]  rx_status;

  assign in_ready = (cnt_r <= 3'd2);
  assign in_xfer  = in_valid && in_ready;
  assign out_valid = (cnt_r != 3'd0);
  assign out_xfer = out_valid && out_ready;
  assign pready   = 1'b1;
  assign cfg_wr   = psel && penable && pwrite;

  always_comb begin
    unique case (paddr[3:2])
      REG_RESP_TO: prdata = {22'd0, resp_to_r};
      REG_GAP_TO:  prdata = {24'd0, gap_to_r};
      REG_CHK_CMD: prdata = {31'd0, chk_cmd_r};
      REG_CHK_DST: prdata = {31'd0, chk_dst_r};
      default:     prdata = 32'd0;
    endcase
  end

  assign tick_inc = (tick_r < TICK_MAX) ? tick_r + 11'd1 : tick_r;
  assign rpos     = 10'(reply_cnt_r - 11'd1);

  always_comb begin
    priority if (reply_cnt_r < 11'd3) begin
      rx_status = ST_SHORT;
    end else if (reply_sum_r != held_r) begin
      rx_status = ST_BAD_SUM;
    end else if (chk_cmd_r && (reply_cmd_r != sent_cmd_r)) begin
      rx_status = ST_WRONG_CMD;
    end else if (chk_dst_r && (reply_dst_r != sent_dst_r)) begin
      rx_status = ST_WRONG_DST;
    end else begin
      rx_status = ST_OK;
    end
  end

  always_comb begin
    phase_nxt     = phase_r;
    send_sum_nxt  = send_sum_r;
    send_cnt_nxt  = send_cnt_r;
    sent_cmd_nxt  = sent_cmd_r;
    sent_dst_nxt  = sent_dst_r;
    tick_nxt      = tick_r;
    reply_sum_nxt = reply_sum_r;
    held_nxt      = held_r;
    reply_cnt_nxt = reply_cnt_r;
    reply_cmd_nxt = reply_cmd_r;
    reply_dst_nxt = reply_dst_r;
    push_n        = 2'd0;
    res0          = '0;
    res1          = '0;
    sum_base      = (phase_r == PH_IDLE) ? 8'd0 : send_sum_r;
    cnt_base      = (phase_r == PH_IDLE) ? 11'd0 : send_cnt_r;
    cnt_inc       = (cnt_base < FRAME_MAX) ? cnt_base + 11'd1 : cnt_base;

    unique case (in_func)
      FUNC_REQ: begin
        if (phase_r == PH_IDLE || phase_r == PH_SEND) begin
          if (phase_r == PH_IDLE) begin
            // new transaction clears everything left from the last one
            sent_cmd_nxt  = 8'd0;
            sent_dst_nxt  = 8'd0;
            tick_nxt      = 11'd0;
            reply_sum_nxt = 8'd0;
            held_nxt      = 8'd0;
            reply_cnt_nxt = 11'd0;
            reply_cmd_nxt = 8'd0;
            reply_dst_nxt = 8'd0;
          end
          if (cnt_base == 11'd0) sent_cmd_nxt = in_data_byte;
          if (cnt_base == 11'd1) sent_dst_nxt = in_data_byte;
          send_sum_nxt = sum_base + in_data_byte;
          send_cnt_nxt = cnt_inc;
          res0 = '{kind: KIND_TX, out_byte: in_data_byte, byte_position: clamp_pos(cnt_base),
                   status: ST_OK, reply_length: 11'd0, last: !in_request_last};
          if (in_request_last) begin
            res1 = '{kind: KIND_TX, out_byte: send_sum_nxt,
                     byte_position: clamp_pos(cnt_inc),
                     status: ST_OK, reply_length: 11'd0, last: 1'b1};
            push_n    = 2'd2;
            phase_nxt = PH_WAIT;
            tick_nxt  = 11'd0;
          end else begin
            push_n    = 2'd1;
            phase_nxt = PH_SEND;
          end
        end
      end
      FUNC_RX: begin
        if (phase_r == PH_WAIT) begin
          held_nxt      = in_data_byte;
          reply_cnt_nxt = 11'd1;
          reply_sum_nxt = 8'd0;
          tick_nxt      = 11'd0;
          phase_nxt     = PH_RECV;
        end else if (phase_r == PH_RECV) begin
          // the held byte goes out now, the new one waits
          if (rpos == 10'd0) reply_cmd_nxt = held_r;
          if (rpos == 10'd1) reply_dst_nxt = held_r;
          reply_sum_nxt = reply_sum_r + held_r;
          held_nxt      = in_data_byte;
          reply_cnt_nxt = (reply_cnt_r < FRAME_MAX) ? reply_cnt_r + 11'd1 : reply_cnt_r;
          tick_nxt      = 11'd0;
          res0 = '{kind: KIND_REPLY, out_byte: held_r, byte_position: rpos,
                   status: ST_OK, reply_length: 11'd0, last: 1'b1};
          push_n = 2'd1;
        end
      end
      FUNC_TICK: begin
        if (phase_r == PH_WAIT) begin
          tick_nxt = tick_inc;
          if (tick_inc > {1'b0, resp_to_r}) begin
            phase_nxt = PH_IDLE;
            res0 = '{kind: KIND_STATUS, out_byte: 8'd0, byte_position: 10'd0,
                     status: ST_NO_RESP, reply_length: 11'd0, last: 1'b1};
            push_n = 2'd1;
          end
        end else if (phase_r == PH_RECV) begin
          tick_nxt = tick_inc;
          if (tick_inc > {3'd0, gap_to_r}) begin
            phase_nxt = PH_IDLE;
            res0 = '{kind: KIND_STATUS, out_byte: 8'd0, byte_position: 10'd0,
                     status: rx_status, reply_length: reply_cnt_r, last: 1'b1};
            push_n = 2'd1;
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_IDLE;
      resp_to_r   <= RESP_TO_RESET;
      gap_to_r    <= GAP_TO_RESET;
      chk_cmd_r   <= 1'b1;
      chk_dst_r   <= 1'b1;
      send_sum_r  <= 8'd0;
      send_cnt_r  <= 11'd0;
      sent_cmd_r  <= 8'd0;
      sent_dst_r  <= 8'd0;
      tick_r      <= 11'd0;
      reply_sum_r <= 8'd0;
      held_r      <= 8'd0;
      reply_cnt_r <= 11'd0;
      reply_cmd_r <= 8'd0;
      reply_dst_r <= 8'd0;
      wr_ptr_r    <= 2'd0;
      rd_ptr_r    <= 2'd0;
      cnt_r       <= 3'd0;
    end else begin
      if (cfg_wr) begin
        unique case (paddr[3:2])
          REG_RESP_TO: resp_to_r <= pwdata[9:0];
          REG_GAP_TO:  gap_to_r  <= pwdata[7:0];
          REG_CHK_CMD: chk_cmd_r <= pwdata[0];
          REG_CHK_DST: chk_dst_r <= pwdata[0];
          default: begin
          end
        endcase
      end
      if (in_xfer) begin
        phase_r     <= phase_nxt;
        send_sum_r  <= send_sum_nxt;
        send_cnt_r  <= send_cnt_nxt;
        sent_cmd_r  <= sent_cmd_nxt;
        sent_dst_r  <= sent_dst_nxt;
        tick_r      <= tick_nxt;
        reply_sum_r <= reply_sum_nxt;
        held_r      <= held_nxt;
        reply_cnt_r <= reply_cnt_nxt;
        reply_cmd_r <= reply_cmd_nxt;
        reply_dst_r <= reply_dst_nxt;
        wr_ptr_r    <= wr_ptr_r + push_n;
      end
      if (out_xfer) rd_ptr_r <= rd_ptr_r + 2'd1;
      cnt_r <= cnt_r + (in_xfer ? {1'b0, push_n} : 3'd0) - {2'd0, out_xfer};
    end
  end

  // result queue storage
  always_ff @(posedge clk) begin
    if (in_xfer && push_n != 2'd0) q_mem[wr_ptr_r] <= res0;
    if (in_xfer && push_n == 2'd2) q_mem[wr_ptr_r + 2'd1] <= res1;
  end

  assign out_kind          = q_mem[rd_ptr_r].kind;
  assign out_out_byte      = q_mem[rd_ptr_r].out_byte;
  assign out_byte_position = q_mem[rd_ptr_r].byte_position;
  assign out_status        = q_mem[rd_ptr_r].status;
  assign out_reply_length  = q_mem[rd_ptr_r].reply_length;
  assign out_last          = q_mem[rd_ptr_r].last;

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= 3'd4)
    else $error("result queue overfilled");

  a_last_req_waits: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer && in_func == FUNC_REQ && in_request_last &&
    (phase_r == PH_IDLE || phase_r == PH_SEND) |=> phase_r == PH_WAIT && cnt_r >= 3'd2)
    else $error("last request byte did not start the reply wait");

  a_idle_ignores_line: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer && in_func != FUNC_REQ && (phase_r == PH_IDLE || phase_r == PH_SEND)
    |=> $stable(phase_r) && $stable(wr_ptr_r))
    else $error("line byte or tick acted outside a reply wait");

  a_status_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind == KIND_STATUS |-> out_last && out_out_byte == 8'd0)
    else $error("status result malformed");

  a_status_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer && in_func == FUNC_TICK && push_n != 2'd0 |=> phase_r == PH_IDLE)
    else $error("status issued without ending the transaction");

endmodule
`default_nettype wire

@@ tb/tb.sv @@
// self-checking testbench for the checksummed request/response framer
`timescale 1ns / 100ps
module tb;
  import crrf_pkg::*;

  localparam int unsigned CYCLE_LIMIT  = 1000000;
  localparam int unsigned RANDOM_ITEMS = 100;
  localparam int unsigned PRINT_LIMIT  = 100;

  typedef enum logic [1:0] {FR_IDLE, FR_SEND, FR_WAIT, FR_RECV} frame_phase_t;
  typedef enum int {RPL_GOOD, RPL_BAD_SUM, RPL_BAD_CMD, RPL_BAD_DST, RPL_NOISE} reply_flavor_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  in_func = FUNC_REQ;
  logic [7:0]  in_data_byte = 8'h00;
  logic        in_request_last = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [1:0]  out_kind;
  logic [7:0]  out_out_byte;
  logic [9:0]  out_byte_position;
  logic [2:0]  out_status;
  logic [10:0] out_reply_length;
  logic        out_last;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [3:0]  paddr = 4'h0;
  logic [31:0] pwdata = 32'h0;
  logic [31:0] prdata;
  logic        pready;

  always #2 clk = ~clk;

  checksummed_request_response_framer u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_func          (in_func),
    .in_data_byte     (in_data_byte),
    .in_request_last  (in_request_last),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_kind         (out_kind),
    .out_out_byte     (out_out_byte),
    .out_byte_position(out_byte_position),
    .out_status       (out_status),
    .out_reply_length (out_reply_length),
    .out_last         (out_last),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready)
  );

  // framer copy: registers and transaction state
  logic [9:0]   cfg_resp_to = RESP_TO_RESET;
  logic [7:0]   cfg_gap_to = GAP_TO_RESET;
  logic         cfg_chk_cmd = 1'b1;
  logic         cfg_chk_dst = 1'b1;
  frame_phase_t fr_phase = FR_IDLE;
  logic [7:0]   snd_sum = 8'h00;
  logic [10:0]  snd_cnt = 11'd0;
  logic [7:0]   snd_cmd = 8'h00;
  logic [7:0]   snd_dst = 8'h00;
  logic [10:0]  tick_cnt = 11'd0;
  logic [7:0]   rpl_sum = 8'h00;
  logic [7:0]   rpl_held = 8'h00;
  logic [10:0]  rpl_cnt = 11'd0;
  logic [7:0]   rpl_cmd = 8'h00;
  logic [7:0]   rpl_dst = 8'h00;

  res_t framer_results_q[$];
  int unsigned mismatch_count = 0;
  int unsigned cycle_count = 0;

  // stimulus bookkeeping
  int   burst_left = 0;
  int   items_sent = 0;
  bit   noise_on = 1'b0;
  logic [7:0] gen_cmd = 8'h00;
  logic [7:0] gen_dst = 8'h00;

  function automatic void push_result(logic [1:0] kind, logic [7:0] b, logic [10:0] pos,
                                      logic [2:0] st, logic [10:0] len, logic lst);
    res_t r;
    r.kind          = kind;
    r.out_byte      = b;
    r.byte_position = (pos > 11'd1023) ? 10'h3ff : pos[9:0];
    r.status        = st;
    r.reply_length  = (len > FRAME_MAX) ? FRAME_MAX : len;
    r.last          = lst;
    framer_results_q.push_back(r);
  endfunction

  function automatic void step_framer(logic [1:0] f, logic [7:0] b, logic req_last);
    logic [10:0] pos;
    logic [7:0]  prev;
    logic [2:0]  st;
    case (f)
      FUNC_REQ: begin
        if (fr_phase == FR_IDLE || fr_phase == FR_SEND) begin
          if (fr_phase == FR_IDLE) begin
            snd_sum = 8'h00; snd_cnt = 11'd0; snd_cmd = 8'h00; snd_dst = 8'h00;
            tick_cnt = 11'd0; rpl_sum = 8'h00; rpl_held = 8'h00; rpl_cnt = 11'd0;
            rpl_cmd = 8'h00; rpl_dst = 8'h00;
            fr_phase = FR_SEND;
          end
          pos = snd_cnt;
          if (pos == 11'd0) snd_cmd = b;
          if (pos == 11'd1) snd_dst = b;
          snd_sum = snd_sum + b;
          if (snd_cnt < FRAME_MAX) snd_cnt = snd_cnt + 11'd1;
          if (!req_last) begin
            push_result(KIND_TX, b, pos, ST_OK, 11'd0, 1'b1);
          end else begin
            push_result(KIND_TX, b, pos, ST_OK, 11'd0, 1'b0);
            push_result(KIND_TX, snd_sum, snd_cnt, ST_OK, 11'd0, 1'b1);
            fr_phase = FR_WAIT;
            tick_cnt = 11'd0;
          end
        end
      end
      FUNC_RX: begin
        if (fr_phase == FR_WAIT) begin
          rpl_held = b;
          rpl_cnt  = 11'd1;
          rpl_sum  = 8'h00;
          tick_cnt = 11'd0;
          fr_phase = FR_RECV;
        end else if (fr_phase == FR_RECV) begin
          // reply bytes go out one byte late
          pos  = rpl_cnt - 11'd1;
          prev = rpl_held;
          if (pos == 11'd0) rpl_cmd = prev;
          if (pos == 11'd1) rpl_dst = prev;
          rpl_sum  = rpl_sum + prev;
          rpl_held = b;
          if (rpl_cnt < FRAME_MAX) rpl_cnt = rpl_cnt + 11'd1;
          tick_cnt = 11'd0;
          push_result(KIND_REPLY, prev, pos, ST_OK, 11'd0, 1'b1);
        end
      end
      FUNC_TICK: begin
        if (fr_phase == FR_WAIT) begin
          if (tick_cnt < TICK_MAX) tick_cnt = tick_cnt + 11'd1;
          if (tick_cnt > {1'b0, cfg_resp_to}) begin
            fr_phase = FR_IDLE;
            push_result(KIND_STATUS, 8'h00, 11'd0, ST_NO_RESP, 11'd0, 1'b1);
          end
        end else if (fr_phase == FR_RECV) begin
          if (tick_cnt < TICK_MAX) tick_cnt = tick_cnt + 11'd1;
          if (tick_cnt > {3'b000, cfg_gap_to}) begin
            // short first, then checksum, command, destination
            if (rpl_cnt < 11'd3) st = ST_SHORT;
            else if (rpl_sum != rpl_held) st = ST_BAD_SUM;
            else if (cfg_chk_cmd && rpl_cmd != snd_cmd) st = ST_WRONG_CMD;
            else if (cfg_chk_dst && rpl_dst != snd_dst) st = ST_WRONG_DST;
            else st = ST_OK;
            fr_phase = FR_IDLE;
            push_result(KIND_STATUS, 8'h00, 11'd0, st, rpl_cnt, 1'b1);
          end
        end
      end
      default: ;
    endcase
  endfunction

  task automatic report_mismatch(input string msg);
    mismatch_count++;
    if (mismatch_count <= PRINT_LIMIT) $display("mismatch: %s", msg);
  endtask

  // result check and prediction on each accepted transfer
  always @(posedge clk) begin : monitor
    res_t exp_r;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (framer_results_q.size() == 0) begin
          report_mismatch("result transfer with nothing expected");
        end else begin
          exp_r = framer_results_q.pop_front();
          if (out_kind !== exp_r.kind)
            report_mismatch($sformatf("kind got %0d exp %0d", out_kind, exp_r.kind));
          if (out_out_byte !== exp_r.out_byte)
            report_mismatch($sformatf("out_byte got %0h exp %0h", out_out_byte,
                                      exp_r.out_byte));
          if (out_byte_position !== exp_r.byte_position)
            report_mismatch($sformatf("byte_position got %0d exp %0d", out_byte_position,
                                      exp_r.byte_position));
          if (out_status !== exp_r.status)
            report_mismatch($sformatf("status got %0d exp %0d", out_status, exp_r.status));
          if (out_reply_length !== exp_r.reply_length)
            report_mismatch($sformatf("reply_length got %0d exp %0d", out_reply_length,
                                      exp_r.reply_length));
          if (out_last !== exp_r.last)
            report_mismatch($sformatf("last got %0d exp %0d", out_last, exp_r.last));
        end
      end
      if (in_valid && in_ready) step_framer(in_func, in_data_byte, in_request_last);
    end
  end

  // receiver stall pattern: free-running, random and mostly-stalled stretches
  int rx_seg_left = 0;
  int rx_seg_mode = 0;
  always @(posedge clk) begin
    if (rx_seg_left == 0) begin
      rx_seg_mode <= $urandom_range(0, 2);
      rx_seg_left <= $urandom_range(5, 60);
    end else begin
      rx_seg_left <= rx_seg_left - 1;
    end
    case (rx_seg_mode)
      0: out_ready <= 1'b1;
      1: out_ready <= 1'($urandom_range(0, 1));
      default: out_ready <= ($urandom_range(0, 7) == 0);
    endcase
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  task automatic send_item(input logic [1:0] f, input logic [7:0] d, input logic req_last);
    int gap;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
      gap = $urandom_range(0, 6);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    in_valid        <= 1'b1;
    in_func         <= f;
    in_data_byte    <= d;
    in_request_last <= req_last;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    burst_left--;
    items_sent++;
  endtask

  // an item the framer ignores in its current phase
  task automatic send_stray(input logic [1:0] f);
    send_item(f, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
    items_sent--;
  endtask

  task automatic send_ticks(input int n);
    int k;
    for (k = 0; k < n; k++) send_item(FUNC_TICK, 8'($urandom_range(0, 255)),
                                      1'($urandom_range(0, 1)));
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    burst_left = 0;
    // let the monitor take the last accepted item first
    @(posedge clk);
    while (framer_results_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [1:0] idx, input logic [31:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_RESP_TO: cfg_resp_to = val[9:0];
      REG_GAP_TO:  cfg_gap_to  = val[7:0];
      REG_CHK_CMD: cfg_chk_cmd = val[0];
      REG_CHK_DST: cfg_chk_dst = val[0];
      default: ;
    endcase
  endtask

  task automatic set_config(input int resp, input int gap, input bit cc, input bit cd);
    cfg_write(REG_RESP_TO, 32'(resp));
    cfg_write(REG_GAP_TO, 32'(gap));
    cfg_write(REG_CHK_CMD, 32'(cc));
    cfg_write(REG_CHK_DST, 32'(cd));
  endtask

  task automatic send_request(input int n);
    int k;
    logic [7:0] b;
    gen_dst = 8'h00;
    for (k = 0; k < n; k++) begin
      b = 8'($urandom_range(0, 255));
      if (k == 0) gen_cmd = b;
      if (k == 1) gen_dst = b;
      if (noise_on && $urandom_range(0, 9) == 0)
        send_stray(($urandom_range(0, 1) != 0) ? FUNC_RX : FUNC_TICK);
      send_item(FUNC_REQ, b, k == n - 1);
    end
  endtask

  task automatic send_reply(input int n, input reply_flavor_t flavor, input int max_gap);
    int k;
    logic [7:0] b;
    logic [7:0] sum;
    sum = 8'h00;
    for (k = 0; k < n; k++) begin
      if (flavor == RPL_NOISE)
        b = 8'($urandom_range(0, 255));
      else if (k == n - 1 && n >= 3)
        b = (flavor == RPL_BAD_SUM) ? sum ^ 8'($urandom_range(1, 255)) : sum;
      else if (k == 0)
        b = (flavor == RPL_BAD_CMD) ? gen_cmd ^ 8'($urandom_range(1, 255)) : gen_cmd;
      else if (k == 1)
        b = (flavor == RPL_BAD_DST) ? gen_dst ^ 8'($urandom_range(1, 255)) : gen_dst;
      else
        b = 8'($urandom_range(0, 255));
      sum = sum + b;
      send_item(FUNC_RX, b, 1'($urandom_range(0, 1)));
      if (k < n - 1) begin
        // silent ticks that stay within the gap limit
        send_ticks($urandom_range(0, max_gap));
        if (noise_on && $urandom_range(0, 9) == 0) send_stray(FUNC_REQ);
      end
    end
  endtask

  // one full transaction, always ending with a status back in idle
  task automatic run_transaction(input int nreq, input int nrep, input reply_flavor_t flavor);
    int w;
    int lim;
    send_request(nreq);
    lim = (cfg_resp_to < 4) ? int'(cfg_resp_to) : 4;
    w = $urandom_range(0, lim);
    send_ticks(w);
    if (noise_on && $urandom_range(0, 3) == 0) send_stray(FUNC_REQ);
    if (nrep == 0) begin
      send_ticks(int'(cfg_resp_to) + 1 - w);
    end else begin
      lim = (cfg_gap_to < 3) ? int'(cfg_gap_to) : 3;
      send_reply(nrep, flavor, lim);
      send_ticks(int'(cfg_gap_to) + 1);
    end
  endtask

  task automatic test_reset_values();
    noise_on = 1'b0;
    run_transaction(3, 4, RPL_GOOD);
    run_transaction(2, 3, RPL_BAD_CMD);
    wait_idle();
  endtask

  task automatic test_status_codes();
    set_config(2, 1, 1'b1, 1'b1);
    send_item(FUNC_RX, 8'hff, 1'b1);
    send_item(FUNC_TICK, 8'h00, 1'b0);
    // one-byte request, a request byte while waiting, then no response
    send_item(FUNC_REQ, 8'hff, 1'b1);
    send_item(FUNC_REQ, 8'h00, 1'b0);
    send_ticks(3);
    // missing request destination compares as zero
    run_transaction(1, 4, RPL_GOOD);
    run_transaction(2, 2, RPL_GOOD);
    run_transaction(2, 3, RPL_BAD_SUM);
    run_transaction(2, 3, RPL_BAD_CMD);
    run_transaction(2, 3, RPL_BAD_DST);
    run_transaction(2, 3, RPL_GOOD);
    wait_idle();
  endtask

  task automatic test_zero_timeouts();
    set_config(0, 0, 1'b1, 1'b1);
    run_transaction(1, 0, RPL_GOOD);
    run_transaction(2, 1, RPL_NOISE);
    run_transaction(3, 5, RPL_GOOD);
    wait_idle();
  endtask

  task automatic test_check_enables();
    int m;
    for (m = 0; m < 4; m++) begin
      set_config(3, 2, m[1], m[0]);
      run_transaction(3, 4, RPL_BAD_CMD);
      run_transaction(3, 4, RPL_BAD_DST);
      wait_idle();
    end
  endtask

  task automatic test_long_frames();
    set_config(3, 2, 1'b1, 1'b1);
    // positions and sums run well past the header bytes
    run_transaction(24, 24, RPL_GOOD);
    wait_idle();
  endtask

  task automatic test_wide_timeouts();
    set_config(40, 16, 1'b0, 1'b0);
    send_request(2);
    send_ticks(40);
    send_reply(3, RPL_GOOD, 16);
    send_ticks(17);
    send_request(1);
    send_ticks(41);
    wait_idle();
  endtask

  task automatic test_random();
    int start;
    int nreq;
    int nrep;
    int pick;
    reply_flavor_t flavor;
    noise_on = 1'b1;
    start = items_sent;
    while (items_sent - start < RANDOM_ITEMS) begin
      wait_idle();
      set_config(($urandom_range(0, 9) == 0) ? $urandom_range(0, 40) : $urandom_range(1, 6),
                 ($urandom_range(0, 9) == 0) ? $urandom_range(0, 12) : $urandom_range(1, 4),
                 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
      repeat (5) begin
        nreq = ($urandom_range(0, 7) == 0) ? 1 : $urandom_range(2, 10);
        pick = $urandom_range(0, 7);
        if (pick == 0) nrep = 0;
        else if (pick == 1) nrep = $urandom_range(1, 2);
        else nrep = $urandom_range(3, 10);
        case ($urandom_range(0, 9))
          0: flavor = RPL_BAD_SUM;
          1: flavor = RPL_BAD_CMD;
          2: flavor = RPL_BAD_DST;
          3: flavor = RPL_NOISE;
          default: flavor = RPL_GOOD;
        endcase
        run_transaction(nreq, nrep, flavor);
      end
    end
    wait_idle();
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    test_reset_values();
    test_status_codes();
    test_zero_timeouts();
    test_check_enables();
    test_long_frames();
    test_wide_timeouts();
    test_random();
    wait_idle();
    repeat (20) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
hw/rtl/crrf_pkg.sv
hw/rtl/checksummed_request_response_framer.sv
tb/tb.sv
